/* hw/rtl/lcd_pkg.sv */
// Shared types and constants for the link cell deframer.
package lcd_pkg;

	localparam logic [7:0]  CMD_VAR_SHORT  = 8'd7;
	localparam logic [7:0]  CMD_VAR_FIRST  = 8'd128;
	localparam logic [15:0] FIXED_LEN      = 16'd509;
	localparam logic [15:0] CAP_RESET      = 16'd8192;

	localparam logic CFG_FOUR_BYTE_ID = 1'b0;
	localparam logic CFG_PAYLOAD_CAP  = 1'b1;

	typedef enum logic [1:0] {
		PH_CID,
		PH_CMD,
		PH_LEN,
		PH_PAY
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_CID     = 3'd0,
		ROLE_CMD     = 3'd1,
		ROLE_LEN     = 3'd2,
		ROLE_KEPT    = 3'd3,
		ROLE_DROPPED = 3'd4
	} role_t;

	typedef struct packed {
		logic        format_error;
		logic [15:0] payload_length;
		logic [7:0]  command;
		logic [31:0] circuit_id;
		logic        cell_done;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
		role_t       byte_role;
	} lcd_result_t;

endpackage

/* hw/rtl/lcd_core.sv */
// Cell parsing state and the per-byte next-state and result logic.
module lcd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic                 four_byte_id,
	input  logic [15:0]          capacity,
	output lcd_pkg::lcd_result_t result
);
	import lcd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] cid_q, cid_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] pay_cnt_q, pay_cnt_d;

	logic        is_var;
	logic        keep;
	logic        pay_last;
	logic [1:0]  last_id;
	logic [15:0] len_full;

	assign last_id  = four_byte_id ? 2'd3 : 2'd1;
	assign is_var   = (rx_byte == CMD_VAR_SHORT) || (rx_byte >= CMD_VAR_FIRST);
	assign keep     = pay_cnt_q < capacity;
	assign pay_last = ({1'b0, pay_cnt_q} + 17'd1) >= {1'b0, len_q};
	assign len_full = len_q | {8'h00, rx_byte};

	// next state
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		cid_d     = cid_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		pay_cnt_d = pay_cnt_q;
		case (phase_q)
			PH_CID: begin
				if (hdr_cnt_q == 2'd0) begin
					cid_d = {24'h0, rx_byte};
					cmd_d = 8'h00;
				end else begin
					cid_d = {cid_q[23:0], rx_byte};
				end
				if (hdr_cnt_q >= last_id) begin
					hdr_cnt_d = 2'd0;
					phase_d   = PH_CMD;
				end else begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end
			end
			PH_CMD: begin
				cmd_d     = rx_byte;
				hdr_cnt_d = 2'd0;
				pay_cnt_d = 16'd0;
				if (is_var) begin
					phase_d = PH_LEN;
				end else if (capacity < FIXED_LEN) begin
					phase_d = PH_CID;
				end else begin
					len_d   = FIXED_LEN;
					phase_d = PH_PAY;
				end
			end
			PH_LEN: begin
				if (hdr_cnt_q == 2'd0) begin
					len_d     = {rx_byte, 8'h00};
					hdr_cnt_d = 2'd1;
				end else begin
					len_d     = len_full;
					hdr_cnt_d = 2'd0;
					phase_d   = (len_full == 16'd0) ? PH_CID : PH_PAY;
				end
			end
			PH_PAY: begin
				if (pay_last) begin
					phase_d   = PH_CID;
					pay_cnt_d = 16'd0;
					hdr_cnt_d = 2'd0;
				end else begin
					pay_cnt_d = pay_cnt_q + 16'd1;
				end
			end
			default: phase_d = PH_CID;
		endcase
	end

	// result fields
	always_comb begin
		result                = '0;
		result.circuit_id     = cid_d;
		result.command        = cmd_d;
		case (phase_q)
			PH_CID: result.byte_role = ROLE_CID;
			PH_CMD: begin
				result.byte_role = ROLE_CMD;
				if (!is_var && (capacity < FIXED_LEN)) begin
					result.cell_done    = 1'b1;
					result.format_error = 1'b1;
				end
			end
			PH_LEN: begin
				result.byte_role = ROLE_LEN;
				result.cell_done = (hdr_cnt_q != 2'd0) && (len_full == 16'd0);
			end
			PH_PAY: begin
				if (keep) begin
					result.byte_role     = ROLE_KEPT;
					result.payload_byte  = rx_byte;
					result.payload_index = pay_cnt_q;
				end else begin
					result.byte_role = ROLE_DROPPED;
				end
				if (pay_last) begin
					result.cell_done      = 1'b1;
					result.payload_length = (len_q < capacity) ? len_q : capacity;
				end
			end
			default: result.byte_role = ROLE_CID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CID;
			hdr_cnt_q <= 2'd0;
			cid_q     <= 32'h0;
			cmd_q     <= 8'h00;
			len_q     <= 16'h0;
			pay_cnt_q <= 16'h0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			cid_q     <= cid_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			pay_cnt_q <= pay_cnt_d;
		end
	end

endmodule

/* hw/rtl/link_cell_deframer.sv */
// Top level of the link cell deframer: input register, parser, result register.
//
// Channel  Dir  Request content
// s_axis   in   one received link byte (tdata = rx_byte)
// m_axis   out  one result per byte (tdata summary fields, tuser role/error, tlast cell end)
// cfg      in   register write: index 0 id width, index 1 payload capacity
//
// One byte per cycle sustained while the output is not stalled; every byte passes
// the input register, then the result register, from input acceptance to result.
// The parser state and all result fields are settled by one pass of logic
// between the two registers; no loop or shared unit limits the rate.
// Reset (arst_n, asynchronous) empties both registers and returns the
// parser to expecting a circuit id; capacity resets to 8192, id width to 2.
// A stalled output holds its request while the input register still takes
// one more byte; s_axis_tready then drops until the result is taken.
module link_cell_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] payload_index,
	                                    // [55:24] circuit_id, [63:56] command,
	                                    // [79:64] payload_length
	output logic [3:0]  m_axis_tuser,   // [2:0] byte_role, [3] format_error
	output logic        m_axis_tlast,   // cell_done
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import lcd_pkg::*;

	// configuration registers
	logic        four_byte_id_q;
	logic [15:0] capacity_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result stage
	logic        valid_s2;
	lcd_result_t result_s2;
	lcd_result_t result;

	logic advance;   // result register can take a new request
	logic step;      // parser consumes the byte in the input register

	assign cfg_ready     = 1'b1;
	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_byte_id_q <= 1'b0;
			capacity_q     <= CAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FOUR_BYTE_ID: four_byte_id_q <= cfg_data[0];
				CFG_PAYLOAD_CAP:  capacity_q     <= cfg_data;
				default:          capacity_q     <= capacity_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	lcd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (byte_s1),
		.four_byte_id (four_byte_id_q),
		.capacity     (capacity_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {result_s2.payload_length, result_s2.command,
	                        result_s2.circuit_id, result_s2.payload_index,
	                        result_s2.payload_byte};
	assign m_axis_tuser  = {result_s2.format_error, result_s2.byte_role};
	assign m_axis_tlast  = result_s2.cell_done;

	// a consumed byte always lands in the result register on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("consumed byte produced no result");

	// an error ends a cell on its command byte, with nothing kept
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.format_error) |->
		(result_s2.cell_done && result_s2.byte_role == ROLE_CMD &&
		 result_s2.payload_length == 16'd0))
		else $error("format error outside a refused fixed cell");

	// a nonzero kept length only appears on the closing byte of a payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.payload_length != 16'd0) |->
		(result_s2.cell_done &&
		 (result_s2.byte_role == ROLE_KEPT || result_s2.byte_role == ROLE_DROPPED)))
		else $error("payload length reported off a cell end");

	// kept bytes never sit at or beyond the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.byte_role == ROLE_KEPT) |->
		(result_s2.payload_index < capacity_q))
		else $error("kept payload byte beyond capacity");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for link_cell_deframer: scripted and random byte streams against a cell predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lcd_pkg::*;

	// Cycles with no request moving on any channel before the run is called hung.
	// The longest planned stall is the output hold (HOLD_CYCLES).
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned ITEM_TARGET = 1850;
	localparam int unsigned HOLD_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_FOUR_BYTE_ID;
	logic [15:0] cfg_data = 16'd0;

	link_cell_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Shared bookkeeping
	// ---------------------------------------------------------------------
	logic [7:0]  link_bytes[$];      // bytes waiting for the input driver
	lcd_result_t cell_results[$];    // predicted results, oldest first
	int unsigned bytes_queued = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	logic        in_taken = 1'b0;    // input request accepted at the last rising edge
	logic        cfg_taken = 1'b0;   // register write accepted at the last rising edge
	logic        steady = 1'b0;      // no idling on either side while set

	// Register values the generator last wrote (used to shape cells)
	logic        gen_four_byte = 1'b0;
	logic [15:0] gen_capacity = CAP_RESET;
	int unsigned big_fixed_cells = 0;

	// ---------------------------------------------------------------------
	// Cell predictor: own copy of registers and parser state
	// ---------------------------------------------------------------------
	logic        prd_four_byte = 1'b0;
	logic [15:0] prd_capacity = CAP_RESET;
	phase_t      prd_phase = PH_CID;
	logic [1:0]  prd_hdr_count = 2'd0;
	logic [31:0] prd_circuit = 32'd0;
	logic [7:0]  prd_command = 8'd0;
	logic [15:0] prd_length = 16'd0;
	logic [15:0] prd_pay_count = 16'd0;

	// Advances the parser by one link byte and returns the result it causes.
	task deframe_byte(input logic [7:0] b, output lcd_result_t r);
		logic [1:0] last_id;
		r = '0;
		last_id = prd_four_byte ? 2'd3 : 2'd1;
		case (prd_phase)
			PH_CID: begin
				r.byte_role = ROLE_CID;
				if (prd_hdr_count == 2'd0) begin
					prd_circuit = {24'd0, b};
					prd_command = 8'd0;
				end else begin
					prd_circuit = {prd_circuit[23:0], b};
				end
				// id width is looked at on every id byte, so a narrowing
				// write mid-id ends the id at once
				if (prd_hdr_count >= last_id) begin
					prd_hdr_count = 2'd0;
					prd_phase = PH_CMD;
				end else begin
					prd_hdr_count = prd_hdr_count + 2'd1;
				end
			end
			PH_CMD: begin
				r.byte_role = ROLE_CMD;
				prd_command = b;
				prd_hdr_count = 2'd0;
				prd_pay_count = 16'd0;
				if (b == CMD_VAR_SHORT || b >= CMD_VAR_FIRST) begin
					prd_phase = PH_LEN;
				end else if (prd_capacity < FIXED_LEN) begin
					// fixed cell refused: ends here, flagged
					r.cell_done = 1'b1;
					r.format_error = 1'b1;
					prd_phase = PH_CID;
				end else begin
					prd_length = FIXED_LEN;
					prd_phase = PH_PAY;
				end
			end
			PH_LEN: begin
				r.byte_role = ROLE_LEN;
				if (prd_hdr_count == 2'd0) begin
					prd_length = {b, 8'd0};
					prd_hdr_count = 2'd1;
				end else begin
					prd_length = prd_length | {8'd0, b};
					prd_hdr_count = 2'd0;
					if (prd_length == 16'd0) begin
						r.cell_done = 1'b1;
						prd_phase = PH_CID;
					end else begin
						prd_phase = PH_PAY;
					end
				end
			end
			default: begin
				if (prd_pay_count < prd_capacity) begin
					r.byte_role = ROLE_KEPT;
					r.payload_byte = b;
					r.payload_index = prd_pay_count;
				end else begin
					r.byte_role = ROLE_DROPPED;
				end
				if ({1'b0, prd_pay_count} + 17'd1 >= {1'b0, prd_length}) begin
					r.cell_done = 1'b1;
					r.payload_length = (prd_length < prd_capacity) ? prd_length : prd_capacity;
					prd_phase = PH_CID;
					prd_pay_count = 16'd0;
					prd_hdr_count = 2'd0;
				end else begin
					prd_pay_count = prd_pay_count + 16'd1;
				end
			end
		endcase
		r.circuit_id = prd_circuit;
		r.command = prd_command;
	endtask

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Monitor: samples every channel at the rising edge, checks results,
	// feeds the predictor and runs the watchdog.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		lcd_result_t want;
		lcd_result_t got_pred;
		if (arst_n) begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			cfg_taken <= cfg_valid && cfg_ready;

			// result first: it always belongs to an older byte than any
			// byte accepted on this same edge
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (cell_results.size() == 0) begin
					$error("result request with no prediction waiting");
					fail_count++;
				end else begin
					want = cell_results.pop_front();
					check_field("byte_role", want.byte_role, m_axis_tuser[2:0]);
					check_field("format_error", want.format_error, m_axis_tuser[3]);
					check_field("cell_done", want.cell_done, m_axis_tlast);
					check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
					check_field("payload_index", want.payload_index, m_axis_tdata[23:8]);
					check_field("circuit_id", want.circuit_id, m_axis_tdata[55:24]);
					check_field("command", want.command, m_axis_tdata[63:56]);
					check_field("payload_length", want.payload_length,
						m_axis_tdata[79:64]);
				end
			end

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FOUR_BYTE_ID)
					prd_four_byte = cfg_data[0];
				else
					prd_capacity = cfg_data;
			end

			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata, got_pred);
				cell_results.push_back(got_pred);
			end

			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Input driver: one byte request at a time from link_bytes, changed on
	// the falling edge; about a third of the cycles idle unless steady.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_taken) begin
			// request still pending: hold it
		end else if (link_bytes.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
			s_axis_tdata <= link_bytes.pop_front();
			s_axis_tvalid <= 1'b1;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Result receiver: random back-pressure, plus one long hold while the
	// sender still has plenty queued so the block fills and stalls its input.
	// ---------------------------------------------------------------------
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_seen > 20 && link_bytes.size() > 64) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 32);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task offer(input logic [7:0] b);
		link_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Register write; only called while the block is drained.
	task write_reg(input logic idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		if (idx == CFG_FOUR_BYTE_ID)
			gen_four_byte = value[0];
		else
			gen_capacity = value;
	endtask

	// Wait until every byte is in and every result is out, then let the
	// clock run on to cover the two-stage pipe.
	task drain;
		do @(negedge clk);
		while (link_bytes.size() != 0 || s_axis_tvalid || cell_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One well-formed cell at the id width last written; payload is random.
	task queue_cell(input logic [31:0] cid, input logic [7:0] cmd, input logic [15:0] len);
		int unsigned n;
		if (gen_four_byte) begin
			offer(cid[31:24]);
			offer(cid[23:16]);
		end
		offer(cid[15:8]);
		offer(cid[7:0]);
		offer(cmd);
		if (cmd == CMD_VAR_SHORT || cmd >= CMD_VAR_FIRST) begin
			offer(len[15:8]);
			offer(len[7:0]);
			n = len;
		end else begin
			n = (gen_capacity >= FIXED_LEN) ? FIXED_LEN : 0;
		end
		for (int k = 0; k < n; k++)
			offer(8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		logic [7:0]  cmd;
		logic [15:0] len;
		int unsigned cells;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Scripted opening, reset registers (2-byte id, capacity 8192):
		// zero-length variable cell, then a short variable cell.
		@(posedge clk);
		queue_cell(32'h0000_FFFF, CMD_VAR_SHORT, 16'd0);
		queue_cell(32'h0000_0000, 8'hFF, 16'd3);
		drain();
		// 4-byte ids, nothing kept: every payload byte dropped, then a
		// fixed cell refused for capacity below a full payload
		write_reg(CFG_FOUR_BYTE_ID, 16'd1);
		write_reg(CFG_PAYLOAD_CAP, 16'd0);
		@(posedge clk);
		queue_cell(32'hFFFF_FFFF, CMD_VAR_FIRST, 16'd2);
		queue_cell(32'h0000_0000, 8'h00, 16'd0);

		// Random phases: registers change between phases, with the parser
		// possibly left mid-cell by stray bytes.
		for (int ph = 0; bytes_queued < ITEM_TARGET; ph++) begin
			drain();
			if (ph == 0) begin
				// a full fixed cell at exactly the capacity that admits it;
				// its length also gives the output hold something to stall
				write_reg(CFG_FOUR_BYTE_ID, 16'd0);
				write_reg(CFG_PAYLOAD_CAP, FIXED_LEN);
			end else begin
				if ($urandom_range(0, 3) != 0)
					write_reg(CFG_FOUR_BYTE_ID, 16'($urandom_range(0, 1)));
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 9))
						0: len = 16'd0;
						1: len = 16'd1;
						2: len = 16'd2;
						3: len = FIXED_LEN - 16'd1;
						4: len = FIXED_LEN;
						5: len = 16'hFFFF;
						6: len = CAP_RESET;
						7: len = 16'($urandom_range(3, 40));
						default: len = 16'($urandom_range(0, 600));
					endcase
					write_reg(CFG_PAYLOAD_CAP, len);
				end
			end

			@(posedge clk);
			steady = (ph == 2) || ($urandom_range(0, 7) == 0);
			if (ph == 0) begin
				queue_cell($urandom, 8'd1, 16'd0);
				big_fixed_cells++;
			end

			cells = $urandom_range(1, 6);
			for (int c = 0; c < cells; c++) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray bytes: breaks the framing for what follows
					repeat ($urandom_range(1, 7)) offer(8'($urandom_range(0, 255)));
				end else begin
					case ($urandom_range(0, 9))
						0: cmd = 8'd0;
						1: cmd = CMD_VAR_SHORT - 8'd1;
						2: cmd = CMD_VAR_SHORT;
						3: cmd = CMD_VAR_SHORT + 8'd1;
						4: cmd = CMD_VAR_FIRST - 8'd1;
						5: cmd = CMD_VAR_FIRST;
						6: cmd = 8'hFF;
						default: cmd = 8'($urandom_range(0, 255));
					endcase
					// full fixed cells are long; allow only a couple
					if (cmd != CMD_VAR_SHORT && cmd < CMD_VAR_FIRST &&
					    gen_capacity >= FIXED_LEN) begin
						if (big_fixed_cells < 2 && $urandom_range(0, 3) == 0)
							big_fixed_cells++;
						else
							cmd = 8'($urandom_range(128, 255));
					end
					case ($urandom_range(0, 9))
						0: len = 16'd0;
						1: len = 16'($urandom_range(100, 300));
						2, 3: len = (gen_capacity < 64) ?
							gen_capacity + 16'($urandom_range(0, 2)) :
							16'($urandom_range(1, 24));
						default: len = 16'($urandom_range(1, 24));
					endcase
					queue_cell($urandom, cmd, len);
				end
			end
		end

		drain();
		steady = 1'b0;
		repeat (8) @(posedge clk);
		if (cell_results.size() != 0) begin
			$error("%0d predicted results never arrived", cell_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
